// ===== src/cbu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbu_pkg - shared types, constants and code tables
// Run and command types used between the front, queue and back, the mode
// and register codes, and the character set translation tables.
// ----------------------------------------------------------------------------
package cbu_pkg;

	localparam int RECORD_MAX = 4096;
	localparam int LEN_W      = 13;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int RUNS_MAX   = 3;

	// conversion modes
	localparam logic [2:0] MODE_COPY    = 3'd0;
	localparam logic [2:0] MODE_E2A     = 3'd1;
	localparam logic [2:0] MODE_UNBLOCK = 3'd2;
	localparam logic [2:0] MODE_A2E     = 3'd3;
	localparam logic [2:0] MODE_A2IBM   = 3'd4;
	localparam logic [2:0] MODE_BLOCK   = 3'd5;

	// register indexes
	localparam logic [1:0] CFG_MODE       = 2'd0;
	localparam logic [1:0] CFG_FOLD_UPPER = 2'd1;
	localparam logic [1:0] CFG_FOLD_LOWER = 2'd2;
	localparam logic [1:0] CFG_RECLEN     = 2'd3;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef struct packed {
		logic [7:0]       value;
		logic [LEN_W-1:0] count;
		logic             trunc;
	} run_t;

	// one input byte worth of runs, packed from slot 0
	typedef struct packed {
		logic [1:0]            n_runs;
		run_t [RUNS_MAX-1:0]   runs;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] TAB_E2A [256] = '{
		8'o000,8'o001,8'o002,8'o003,8'o234,8'o011,8'o206,8'o177,
		8'o227,8'o215,8'o216,8'o013,8'o014,8'o015,8'o016,8'o017,
		8'o020,8'o021,8'o022,8'o023,8'o235,8'o205,8'o010,8'o207,
		8'o030,8'o031,8'o222,8'o217,8'o034,8'o035,8'o036,8'o037,
		8'o200,8'o201,8'o202,8'o203,8'o204,8'o012,8'o027,8'o033,
		8'o210,8'o211,8'o212,8'o213,8'o214,8'o005,8'o006,8'o007,
		8'o220,8'o221,8'o026,8'o223,8'o224,8'o225,8'o226,8'o004,
		8'o230,8'o231,8'o232,8'o233,8'o024,8'o025,8'o236,8'o032,
		8'o040,8'o240,8'o241,8'o242,8'o243,8'o244,8'o245,8'o246,
		8'o247,8'o250,8'o133,8'o056,8'o074,8'o050,8'o053,8'o041,
		8'o046,8'o251,8'o252,8'o253,8'o254,8'o255,8'o256,8'o257,
		8'o260,8'o261,8'o135,8'o044,8'o052,8'o051,8'o073,8'o136,
		8'o055,8'o057,8'o262,8'o263,8'o264,8'o265,8'o266,8'o267,
		8'o270,8'o271,8'o174,8'o054,8'o045,8'o137,8'o076,8'o077,
		8'o272,8'o273,8'o274,8'o275,8'o276,8'o277,8'o300,8'o301,
		8'o302,8'o140,8'o072,8'o043,8'o100,8'o047,8'o075,8'o042,
		8'o303,8'o141,8'o142,8'o143,8'o144,8'o145,8'o146,8'o147,
		8'o150,8'o151,8'o304,8'o305,8'o306,8'o307,8'o310,8'o311,
		8'o312,8'o152,8'o153,8'o154,8'o155,8'o156,8'o157,8'o160,
		8'o161,8'o162,8'o313,8'o314,8'o315,8'o316,8'o317,8'o320,
		8'o321,8'o176,8'o163,8'o164,8'o165,8'o166,8'o167,8'o170,
		8'o171,8'o172,8'o322,8'o323,8'o324,8'o325,8'o326,8'o327,
		8'o330,8'o331,8'o332,8'o333,8'o334,8'o335,8'o336,8'o337,
		8'o340,8'o341,8'o342,8'o343,8'o344,8'o345,8'o346,8'o347,
		8'o173,8'o101,8'o102,8'o103,8'o104,8'o105,8'o106,8'o107,
		8'o110,8'o111,8'o350,8'o351,8'o352,8'o353,8'o354,8'o355,
		8'o175,8'o112,8'o113,8'o114,8'o115,8'o116,8'o117,8'o120,
		8'o121,8'o122,8'o356,8'o357,8'o360,8'o361,8'o362,8'o363,
		8'o134,8'o237,8'o123,8'o124,8'o125,8'o126,8'o127,8'o130,
		8'o131,8'o132,8'o364,8'o365,8'o366,8'o367,8'o370,8'o371,
		8'o060,8'o061,8'o062,8'o063,8'o064,8'o065,8'o066,8'o067,
		8'o070,8'o071,8'o372,8'o373,8'o374,8'o375,8'o376,8'o377
	};

	localparam logic [7:0] TAB_A2E [256] = '{
		8'o000,8'o001,8'o002,8'o003,8'o067,8'o055,8'o056,8'o057,
		8'o026,8'o005,8'o045,8'o013,8'o014,8'o015,8'o016,8'o017,
		8'o020,8'o021,8'o022,8'o023,8'o074,8'o075,8'o062,8'o046,
		8'o030,8'o031,8'o077,8'o047,8'o034,8'o035,8'o036,8'o037,
		8'o100,8'o117,8'o177,8'o173,8'o133,8'o154,8'o120,8'o175,
		8'o115,8'o135,8'o134,8'o116,8'o153,8'o140,8'o113,8'o141,
		8'o360,8'o361,8'o362,8'o363,8'o364,8'o365,8'o366,8'o367,
		8'o370,8'o371,8'o172,8'o136,8'o114,8'o176,8'o156,8'o157,
		8'o174,8'o301,8'o302,8'o303,8'o304,8'o305,8'o306,8'o307,
		8'o310,8'o311,8'o321,8'o322,8'o323,8'o324,8'o325,8'o326,
		8'o327,8'o330,8'o331,8'o342,8'o343,8'o344,8'o345,8'o346,
		8'o347,8'o350,8'o351,8'o112,8'o340,8'o132,8'o137,8'o155,
		8'o171,8'o201,8'o202,8'o203,8'o204,8'o205,8'o206,8'o207,
		8'o210,8'o211,8'o221,8'o222,8'o223,8'o224,8'o225,8'o226,
		8'o227,8'o230,8'o231,8'o242,8'o243,8'o244,8'o245,8'o246,
		8'o247,8'o250,8'o251,8'o300,8'o152,8'o320,8'o241,8'o007,
		8'o040,8'o041,8'o042,8'o043,8'o044,8'o025,8'o006,8'o027,
		8'o050,8'o051,8'o052,8'o053,8'o054,8'o011,8'o012,8'o033,
		8'o060,8'o061,8'o032,8'o063,8'o064,8'o065,8'o066,8'o010,
		8'o070,8'o071,8'o072,8'o073,8'o004,8'o024,8'o076,8'o341,
		8'o101,8'o102,8'o103,8'o104,8'o105,8'o106,8'o107,8'o110,
		8'o111,8'o121,8'o122,8'o123,8'o124,8'o125,8'o126,8'o127,
		8'o130,8'o131,8'o142,8'o143,8'o144,8'o145,8'o146,8'o147,
		8'o150,8'o151,8'o160,8'o161,8'o162,8'o163,8'o164,8'o165,
		8'o166,8'o167,8'o170,8'o200,8'o212,8'o213,8'o214,8'o215,
		8'o216,8'o217,8'o220,8'o232,8'o233,8'o234,8'o235,8'o236,
		8'o237,8'o240,8'o252,8'o253,8'o254,8'o255,8'o256,8'o257,
		8'o260,8'o261,8'o262,8'o263,8'o264,8'o265,8'o266,8'o267,
		8'o270,8'o271,8'o272,8'o273,8'o274,8'o275,8'o276,8'o277,
		8'o312,8'o313,8'o314,8'o315,8'o316,8'o317,8'o332,8'o333,
		8'o334,8'o335,8'o336,8'o337,8'o352,8'o353,8'o354,8'o355,
		8'o356,8'o357,8'o372,8'o373,8'o374,8'o375,8'o376,8'o377
	};

	localparam logic [7:0] TAB_A2IBM [256] = '{
		8'o000,8'o001,8'o002,8'o003,8'o067,8'o055,8'o056,8'o057,
		8'o026,8'o005,8'o045,8'o013,8'o014,8'o015,8'o016,8'o017,
		8'o020,8'o021,8'o022,8'o023,8'o074,8'o075,8'o062,8'o046,
		8'o030,8'o031,8'o077,8'o047,8'o034,8'o035,8'o036,8'o037,
		8'o100,8'o132,8'o177,8'o173,8'o133,8'o154,8'o120,8'o175,
		8'o115,8'o135,8'o134,8'o116,8'o153,8'o140,8'o113,8'o141,
		8'o360,8'o361,8'o362,8'o363,8'o364,8'o365,8'o366,8'o367,
		8'o370,8'o371,8'o172,8'o136,8'o114,8'o176,8'o156,8'o157,
		8'o174,8'o301,8'o302,8'o303,8'o304,8'o305,8'o306,8'o307,
		8'o310,8'o311,8'o321,8'o322,8'o323,8'o324,8'o325,8'o326,
		8'o327,8'o330,8'o331,8'o342,8'o343,8'o344,8'o345,8'o346,
		8'o347,8'o350,8'o351,8'o255,8'o340,8'o275,8'o137,8'o155,
		8'o171,8'o201,8'o202,8'o203,8'o204,8'o205,8'o206,8'o207,
		8'o210,8'o211,8'o221,8'o222,8'o223,8'o224,8'o225,8'o226,
		8'o227,8'o230,8'o231,8'o242,8'o243,8'o244,8'o245,8'o246,
		8'o247,8'o250,8'o251,8'o300,8'o117,8'o320,8'o241,8'o007,
		8'o040,8'o041,8'o042,8'o043,8'o044,8'o025,8'o006,8'o027,
		8'o050,8'o051,8'o052,8'o053,8'o054,8'o011,8'o012,8'o033,
		8'o060,8'o061,8'o032,8'o063,8'o064,8'o065,8'o066,8'o010,
		8'o070,8'o071,8'o072,8'o073,8'o004,8'o024,8'o076,8'o341,
		8'o101,8'o102,8'o103,8'o104,8'o105,8'o106,8'o107,8'o110,
		8'o111,8'o121,8'o122,8'o123,8'o124,8'o125,8'o126,8'o127,
		8'o130,8'o131,8'o142,8'o143,8'o144,8'o145,8'o146,8'o147,
		8'o150,8'o151,8'o160,8'o161,8'o162,8'o163,8'o164,8'o165,
		8'o166,8'o167,8'o170,8'o200,8'o212,8'o213,8'o214,8'o215,
		8'o216,8'o217,8'o220,8'o232,8'o233,8'o234,8'o235,8'o236,
		8'o237,8'o240,8'o252,8'o253,8'o254,8'o255,8'o256,8'o257,
		8'o260,8'o261,8'o262,8'o263,8'o264,8'o265,8'o266,8'o267,
		8'o270,8'o271,8'o272,8'o273,8'o274,8'o275,8'o276,8'o277,
		8'o312,8'o313,8'o314,8'o315,8'o316,8'o317,8'o332,8'o333,
		8'o334,8'o335,8'o336,8'o337,8'o352,8'o353,8'o354,8'o355,
		8'o356,8'o357,8'o372,8'o373,8'o374,8'o375,8'o376,8'o377
	};

	// upper folding first, then lower folding
	function automatic logic [7:0] fold_case(input logic [7:0] c, input logic up,
			input logic lo);
		logic [7:0] r;
		r = c;
		if (up && r >= CH_LA && r <= CH_LZ) begin
			r = r - CASE_GAP;
		end
		if (lo && r >= CH_UA && r <= CH_UZ) begin
			r = r + CASE_GAP;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/cbu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbu_front - configuration, translation and record bookkeeping
// Takes one byte a cycle while the queue is not full, translates and folds it,
// tracks the record position and held spaces, and packs its runs into one command.
// ----------------------------------------------------------------------------
module cbu_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [cbu_pkg::LEN_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 in_byte,
	input  wire cbu_pkg::q_stat_t           q_stat,
	output logic                            push,
	output cbu_pkg::cmd_t                   push_cmd
);

	logic [2:0]                mode_q;
	logic                      fold_up_q;
	logic                      fold_lo_q;
	logic [cbu_pkg::LEN_W-1:0] reclen_q;
	logic [cbu_pkg::LEN_W-1:0] pos_q;
	logic [cbu_pkg::LEN_W-1:0] spaces_q;
	logic                      spaces_nz_q;

	logic [cbu_pkg::LEN_W-1:0] cbs;
	logic [cbu_pkg::LEN_W-1:0] pos_d;
	logic [cbu_pkg::LEN_W-1:0] spaces_d;
	logic                      spaces_nz_d;
	logic [cbu_pkg::LEN_W:0]   pos_inc;
	logic [cbu_pkg::LEN_W:0]   cbs_p1;
	logic [7:0]                x_unb;
	logic [7:0]                x_fold;
	logic [7:0]                x_blk;
	logic [7:0]                pad;
	logic [1:0]                k;
	logic                      accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign push      = accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= cbu_pkg::MODE_COPY;
			fold_up_q <= 1'b0;
			fold_lo_q <= 1'b0;
			reclen_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbu_pkg::CFG_MODE:       mode_q    <= cfg_data[2:0];
				cbu_pkg::CFG_FOLD_UPPER: fold_up_q <= cfg_data[0];
				cbu_pkg::CFG_FOLD_LOWER: fold_lo_q <= cfg_data[0];
				cbu_pkg::CFG_RECLEN:     reclen_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective record length, clipped to the maximum
	assign cbs = (reclen_q > cbu_pkg::LEN_W'(cbu_pkg::RECORD_MAX)) ?
		cbu_pkg::LEN_W'(cbu_pkg::RECORD_MAX) : reclen_q;
	assign cbs_p1  = {1'b0, cbs} + (cbu_pkg::LEN_W+1)'(1);
	assign pos_inc = {1'b0, pos_q} + (cbu_pkg::LEN_W+1)'(1);

	// translation: unblocking folds after, blocking folds before
	assign x_unb  = (mode_q == cbu_pkg::MODE_E2A) ? cbu_pkg::TAB_E2A[in_byte] : in_byte;
	assign x_fold = cbu_pkg::fold_case(in_byte, fold_up_q, fold_lo_q);

	always_comb begin
		case (mode_q)
			cbu_pkg::MODE_A2E: begin
				x_blk = cbu_pkg::TAB_A2E[x_fold];
				pad   = cbu_pkg::TAB_A2E[cbu_pkg::CH_SPACE];
			end
			cbu_pkg::MODE_A2IBM: begin
				x_blk = cbu_pkg::TAB_A2IBM[x_fold];
				pad   = cbu_pkg::TAB_A2IBM[cbu_pkg::CH_SPACE];
			end
			default: begin
				x_blk = x_fold;
				pad   = cbu_pkg::CH_SPACE;
			end
		endcase
	end

	// build the command and next record state
	always_comb begin
		push_cmd    = '0;
		k           = 2'd0;
		pos_d       = pos_q;
		spaces_d    = spaces_q;
		spaces_nz_d = spaces_nz_q;
		case (mode_q) inside
			cbu_pkg::MODE_E2A, cbu_pkg::MODE_UNBLOCK: begin
				if (cbs == '0) begin
					push_cmd.runs[k] = '{cbu_pkg::fold_case(x_unb, fold_up_q, fold_lo_q),
						cbu_pkg::LEN_W'(1), 1'b0};
					k = k + 2'd1;
				end else begin
					if (x_unb == cbu_pkg::CH_SPACE) begin
						spaces_d    = spaces_q + cbu_pkg::LEN_W'(1);
						spaces_nz_d = 1'b1;
					end else begin
						// held flag, as the count alone wraps at its width
						if (spaces_nz_q) begin
							push_cmd.runs[k] = '{cbu_pkg::CH_SPACE, spaces_q, 1'b0};
							k = k + 2'd1;
						end
						spaces_d    = '0;
						spaces_nz_d = 1'b0;
						push_cmd.runs[k] = '{cbu_pkg::fold_case(x_unb, fold_up_q,
							fold_lo_q), cbu_pkg::LEN_W'(1), 1'b0};
						k = k + 2'd1;
					end
					// record end: newline, both counters clear
					if (pos_inc >= {1'b0, cbs}) begin
						push_cmd.runs[k] = '{cbu_pkg::CH_NL, cbu_pkg::LEN_W'(1), 1'b0};
						k           = k + 2'd1;
						pos_d       = '0;
						spaces_d    = '0;
						spaces_nz_d = 1'b0;
					end else begin
						pos_d = pos_inc[cbu_pkg::LEN_W-1:0];
					end
				end
			end
			cbu_pkg::MODE_A2E, cbu_pkg::MODE_A2IBM, cbu_pkg::MODE_BLOCK: begin
				if (cbs == '0) begin
					push_cmd.runs[k] = '{x_blk, cbu_pkg::LEN_W'(1), 1'b0};
					k = k + 2'd1;
				end else if (in_byte == cbu_pkg::CH_NL) begin
					// newline pads out the rest of the record
					if (pos_q < cbs) begin
						push_cmd.runs[k] = '{pad, cbs - pos_q, 1'b0};
						k = k + 2'd1;
					end
					pos_d = '0;
				end else begin
					if (pos_inc > cbs_p1) begin
						pos_d = cbs_p1[cbu_pkg::LEN_W-1:0];
					end else begin
						pos_d = pos_inc[cbu_pkg::LEN_W-1:0];
					end
					if (pos_inc <= {1'b0, cbs}) begin
						push_cmd.runs[k] = '{x_blk, cbu_pkg::LEN_W'(1), 1'b0};
						k = k + 2'd1;
					end else if (pos_q == cbs) begin
						// first byte dropped from this record
						push_cmd.runs[k] = '{8'h00, '0, 1'b1};
						k = k + 2'd1;
					end
				end
			end
			default: begin
				push_cmd.runs[k] = '{x_fold, cbu_pkg::LEN_W'(1), 1'b0};
				k = k + 2'd1;
			end
		endcase
		// nothing produced: one empty run
		if (k == 2'd0) begin
			k = 2'd1;
		end
		push_cmd.n_runs = k;
	end

	// record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			spaces_q    <= '0;
			spaces_nz_q <= 1'b0;
		end else if (accept) begin
			pos_q       <= pos_d;
			spaces_q    <= spaces_d;
			spaces_nz_q <= spaces_nz_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/cbu_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbu_queue - command queue between front and back
// A small register queue; the head is shown combinationally to the back.
// ----------------------------------------------------------------------------
module cbu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cbu_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output cbu_pkg::cmd_t      head_cmd,
	output cbu_pkg::q_stat_t   q_stat
);

	cbu_pkg::cmd_t              entry_q [cbu_pkg::QDEPTH];
	logic [cbu_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [cbu_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [cbu_pkg::QPTR_W:0]   count_q;

	assign head_cmd     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (cbu_pkg::QPTR_W+1)'(cbu_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + cbu_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + cbu_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (cbu_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (cbu_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/cbu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbu_back - run emitter
// Walks the runs of the head command, one word a cycle unless stalled, into the
// output register; pops the command after its last run.
// ----------------------------------------------------------------------------
module cbu_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cbu_pkg::cmd_t             head_cmd,
	input  wire cbu_pkg::q_stat_t          q_stat,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [7:0]                     out_byte,
	output logic [cbu_pkg::LEN_W-1:0]      repeat_res,
	output logic                           truncated_record,
	output logic                           last
);

	logic       valid_q;
	logic [1:0] idx_q;
	logic       load;
	logic       final_run;

	cbu_pkg::run_t run_q;
	logic          last_q;

	assign load      = !q_stat.empty && (!valid_q || out_ready);
	assign final_run = (idx_q == head_cmd.n_runs - 2'd1);
	assign pop       = load && final_run;

	// run index within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= final_run ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) begin
			run_q  <= head_cmd.runs[idx_q];
			last_q <= final_run;
		end
	end

	assign out_valid        = valid_q;
	assign out_byte         = run_q.value;
	assign repeat_res       = run_q.count;
	assign truncated_record = run_q.trunc;
	assign last             = last_q;

endmodule
`default_nettype wire

// ===== src/charset_block_unblock_converter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// charset_block_unblock_converter - character set converter with blocking
// Translates and case-folds a byte stream and turns it into fixed records
// or newline-ended lines, giving runs of byte value and repeat count.
// ----------------------------------------------------------------------------
// The first run of a byte passes through the command queue and then the output
// register. Throughput: one byte a cycle while each byte gives one run and the
// output is not stalled; the runs of a byte are emitted one after another by the
// single run emitter. A four-entry command queue absorbs short output stalls.
// Reset: asynchronous, clears registers to zero, record state and queue empty.
module charset_block_unblock_converter (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [cbu_pkg::LEN_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                in_byte,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [7:0]                     out_byte,
	output logic [cbu_pkg::LEN_W-1:0]      repeat_res,
	output logic                           truncated_record,
	output logic                           last
);

	cbu_pkg::cmd_t    push_cmd;
	cbu_pkg::cmd_t    head_cmd;
	cbu_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	cbu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	cbu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	cbu_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_cmd         (head_cmd),
		.q_stat           (q_stat),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.repeat_res       (repeat_res),
		.truncated_record (truncated_record),
		.last             (last)
	);

endmodule
`default_nettype wire

// ===== src/cbu_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbu_checker - port-level checks for the converter
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
module cbu_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      cfg_valid,
	input wire logic                      cfg_ready,
	input wire logic [1:0]                cfg_index,
	input wire logic [cbu_pkg::LEN_W-1:0] cfg_data,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic [7:0]                in_byte,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [7:0]                out_byte,
	input wire logic [cbu_pkg::LEN_W-1:0] repeat_res,
	input wire logic                      truncated_record,
	input wire logic                      last
);

	// no word offered while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word valid during reset");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(repeat_res) && $stable(truncated_record) && $stable(last))
		else $error("stalled output word changed");

	// an empty run is the only run of its byte
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeat_res == '0 |-> last && out_byte == 8'h00)
		else $error("empty run not alone");

	// truncation flag only rides on an empty run
	a_trunc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated_record |-> repeat_res == '0)
		else $error("truncation flag on a data run");

endmodule

bind charset_block_unblock_converter cbu_checker u_cbu_checker (.*);
`default_nettype wire

// ===== bench/charset_block_unblock_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charset_block_unblock_converter_test - self-checking bench for the converter
// Walks a short table of directed bytes and register writes, then random
// phases of record-shaped byte streams under random settings. Each output word
// is checked against its fixed answer or a local model of translation, folding,
// blocking and unblocking, with random idling on the input and output channels.
// ----------------------------------------------------------------------------
module charset_block_unblock_converter_test;

	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam logic [7:0] EBC_SPACE    = 8'h40;
	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT  = 600000;

	// one expected output word
	typedef struct packed {
		logic [7:0]                val;
		logic [cbu_pkg::LEN_W-1:0] cnt;
		logic                      trunc;
		logic                      fin;
	} run_word_t;

	// directed row: a register write or a byte, optionally with a fixed answer
	typedef struct packed {
		logic                      is_cfg;
		logic [1:0]                idx;
		logic [cbu_pkg::LEN_W-1:0] data;
		logic                      fixed;
		run_word_t                 want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [cbu_pkg::LEN_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [7:0] in_byte;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_byte;
	logic [cbu_pkg::LEN_W-1:0] repeat_res;
	logic truncated_record;
	logic last;

	// fixed answer travelling with the byte on the input channel
	logic typed_on;
	run_word_t typed_run;

	// mirror of the registers and record state
	logic [2:0] mode_r;
	logic up_r;
	logic lo_r;
	logic [cbu_pkg::LEN_W-1:0] reclen_r;
	int pos_r;
	int held_r;

	run_word_t runs_due[$];
	run_word_t want_w;
	stim_row_t stim_tab[$];
	logic steady;
	int errors;
	int word_no;
	int cycles;

	charset_block_unblock_converter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.repeat_res       (repeat_res),
		.truncated_record (truncated_record),
		.last             (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic run_word_t mk_run(input logic [7:0] v,
			input logic [cbu_pkg::LEN_W-1:0] c, input logic t);
		run_word_t r;
		r.val = v;
		r.cnt = c;
		r.trunc = t;
		r.fin = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t row_cfg(input logic [1:0] idx,
			input logic [cbu_pkg::LEN_W-1:0] d);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = d;
		return r;
	endfunction

	function automatic stim_row_t row_byte(input logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.data = cbu_pkg::LEN_W'(b);
		return r;
	endfunction

	function automatic stim_row_t row_fixed(input logic [7:0] b, input logic [7:0] v,
			input logic [cbu_pkg::LEN_W-1:0] c, input logic t);
		stim_row_t r;
		r = row_byte(b);
		r.fixed = 1'b1;
		r.want = mk_run(v, c, t);
		r.want.fin = 1'b1;
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	// upper folding first, lower folding second
	function automatic logic [7:0] fold_letter(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (up_r && r >= cbu_pkg::CH_LA && r <= cbu_pkg::CH_LZ)
			r = r - cbu_pkg::CH_LA + cbu_pkg::CH_UA;
		if (lo_r && r >= cbu_pkg::CH_UA && r <= cbu_pkg::CH_UZ)
			r = r - cbu_pkg::CH_UA + cbu_pkg::CH_LA;
		return r;
	endfunction

	// work out the runs one accepted byte gives and queue them
	task automatic predict_byte(input logic [7:0] c, input logic fx, input run_word_t w);
		run_word_t step_q[$];
		int cbs;
		int np;
		logic first_over;
		logic [7:0] x;
		logic [7:0] pad;
		cbs = (reclen_r > cbu_pkg::RECORD_MAX) ? cbu_pkg::RECORD_MAX : int'(reclen_r);
		case (mode_r) inside
			cbu_pkg::MODE_E2A, cbu_pkg::MODE_UNBLOCK: begin
				x = (mode_r == cbu_pkg::MODE_E2A) ? cbu_pkg::TAB_E2A[c] : c;
				if (cbs == 0) begin
					step_q.push_back(mk_run(fold_letter(x), 1, 1'b0));
				end else begin
					if (x == cbu_pkg::CH_SPACE) begin
						held_r++;
					end else begin
						if (held_r != 0)
							step_q.push_back(mk_run(cbu_pkg::CH_SPACE,
								cbu_pkg::LEN_W'(held_r), 1'b0));
						held_r = 0;
						step_q.push_back(mk_run(fold_letter(x), 1, 1'b0));
					end
					pos_r++;
					// record complete: newline, and the held spaces are dropped
					if (pos_r >= cbs) begin
						step_q.push_back(mk_run(cbu_pkg::CH_NL, 1, 1'b0));
						pos_r = 0;
						held_r = 0;
					end
				end
			end
			cbu_pkg::MODE_A2E, cbu_pkg::MODE_A2IBM, cbu_pkg::MODE_BLOCK: begin
				x = fold_letter(c);
				if (mode_r == cbu_pkg::MODE_A2E) begin
					x = cbu_pkg::TAB_A2E[x];
					pad = cbu_pkg::TAB_A2E[cbu_pkg::CH_SPACE];
				end else if (mode_r == cbu_pkg::MODE_A2IBM) begin
					x = cbu_pkg::TAB_A2IBM[x];
					pad = cbu_pkg::TAB_A2IBM[cbu_pkg::CH_SPACE];
				end else begin
					pad = cbu_pkg::CH_SPACE;
				end
				if (cbs == 0) begin
					step_q.push_back(mk_run(x, 1, 1'b0));
				end else if (c == cbu_pkg::CH_NL) begin
					if (pos_r < cbs)
						step_q.push_back(mk_run(pad, cbu_pkg::LEN_W'(cbs - pos_r), 1'b0));
					pos_r = 0;
				end else begin
					// position saturates one past the record length
					first_over = (pos_r == cbs);
					np = pos_r + 1;
					if (np > cbs + 1) np = cbs + 1;
					pos_r = np;
					if (np <= cbs) step_q.push_back(mk_run(x, 1, 1'b0));
					else if (first_over) step_q.push_back(mk_run(8'h00, 0, 1'b1));
				end
			end
			default: begin
				step_q.push_back(mk_run(fold_letter(c), 1, 1'b0));
			end
		endcase
		if (step_q.size() == 0) step_q.push_back(mk_run(8'h00, 0, 1'b0));
		step_q[step_q.size() - 1].fin = 1'b1;
		if (fx) begin
			runs_due.push_back(w);
		end else begin
			foreach (step_q[i]) runs_due.push_back(step_q[i]);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp);
		$display("word %0d: %s got 0x%0h expected 0x%0h", word_no, what, got, exp);
		errors++;
	endtask

	// monitor: mirror register writes, predict accepted bytes, check words
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cbu_pkg::CFG_MODE:       mode_r = cfg_data[2:0];
					cbu_pkg::CFG_FOLD_UPPER: up_r = cfg_data[0];
					cbu_pkg::CFG_FOLD_LOWER: lo_r = cfg_data[0];
					cbu_pkg::CFG_RECLEN:     reclen_r = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_byte(in_byte, typed_on, typed_run);
			if (out_valid && out_ready) begin
				word_no++;
				if (runs_due.size() == 0) begin
					report_mismatch("unexpected word, out_byte", out_byte, 0);
				end else begin
					want_w = runs_due.pop_front();
					if (out_byte !== want_w.val)
						report_mismatch("out_byte", out_byte, want_w.val);
					if (repeat_res !== want_w.cnt)
						report_mismatch("repeat_res", repeat_res, want_w.cnt);
					if (truncated_record !== want_w.trunc)
						report_mismatch("truncated_record", truncated_record, want_w.trunc);
					if (last !== want_w.fin)
						report_mismatch("last", last, want_w.fin);
				end
			end
		end
	end

	// output side back-pressure
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (steady) begin
				out_ready = 1'b1;
			end else if (hold > 0) begin
				hold--;
			end else if (out_ready) begin
				out_ready = 1'b0;
				hold = idle_len();
			end else begin
				out_ready = 1'b1;
				hold = $urandom_range(0, 9);
			end
		end
	end

	task automatic wait_drained();
		while (runs_due.size() != 0) @(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic cfg_write(input logic [1:0] idx, input logic [cbu_pkg::LEN_W-1:0] d);
		in_valid = 1'b0;
		wait_drained();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// offer one byte; returns at the falling edge after it is taken
	task automatic push_byte(input logic [7:0] b, input logic fx, input run_word_t w);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = b;
		typed_on = fx;
		typed_run = w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// cycle limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int byte_cnt;
		int n;
		int r;
		logic [7:0] b;
		logic [cbu_pkg::LEN_W-1:0] d;
		logic first_phase;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_byte = '0;
		typed_on = 1'b0;
		typed_run = '0;
		steady = 1'b0;
		errors = 0;
		word_no = 0;
		mode_r = cbu_pkg::MODE_COPY;
		up_r = 1'b0;
		lo_r = 1'b0;
		reclen_r = '0;
		pos_r = 0;
		held_r = 0;

		// after reset: plain copy, extremes and letters
		stim_tab.push_back(row_fixed(8'h00, 8'h00, 1, 1'b0));
		stim_tab.push_back(row_fixed(8'hff, 8'hff, 1, 1'b0));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_LA, cbu_pkg::CH_LA, 1, 1'b0));
		// upper folding alone, then both (lower wins)
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_FOLD_UPPER, 1));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_LZ, cbu_pkg::CH_UZ, 1, 1'b0));
		stim_tab.push_back(row_fixed(8'h7b, 8'h7b, 1, 1'b0));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_FOLD_LOWER, 1));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_LA, cbu_pkg::CH_LA, 1, 1'b0));
		stim_tab.push_back(row_fixed(8'h51, 8'h71, 1, 1'b0));
		// unused mode code acts as copy
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(MODE_SPARE_7)));
		stim_tab.push_back(row_fixed(8'h4d, 8'h6d, 1, 1'b0));
		// unblocking, record of three: held spaces, dropped trailing spaces
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_FOLD_UPPER, 0));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_FOLD_LOWER, 0));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(cbu_pkg::MODE_UNBLOCK)));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_RECLEN, 3));
		stim_tab.push_back(row_byte(8'h78));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_SPACE, 8'h00, 0, 1'b0));
		stim_tab.push_back(row_byte(cbu_pkg::CH_SPACE));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_SPACE, 8'h00, 0, 1'b0));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_SPACE, 8'h00, 0, 1'b0));
		stim_tab.push_back(row_byte(8'h63));
		// EBCDIC to ASCII unblocking, record of two
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(cbu_pkg::MODE_E2A)));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_RECLEN, 2));
		stim_tab.push_back(row_fixed(EBC_SPACE, 8'h00, 0, 1'b0));
		stim_tab.push_back(row_byte(8'hc1));
		// blocking: overflow flagged once, later drops silent, newline pads
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(cbu_pkg::MODE_BLOCK)));
		stim_tab.push_back(row_byte(cbu_pkg::CH_LA));
		stim_tab.push_back(row_byte(8'h62));
		stim_tab.push_back(row_fixed(8'h63, 8'h00, 0, 1'b1));
		stim_tab.push_back(row_fixed(8'h64, 8'h00, 0, 1'b0));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_NL, 8'h00, 0, 1'b0));
		stim_tab.push_back(row_byte(8'h65));
		stim_tab.push_back(row_byte(cbu_pkg::CH_NL));
		// oversized record length saturates: full pad on an empty record
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(cbu_pkg::MODE_A2E)));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_RECLEN, 13'h1fff));
		stim_tab.push_back(row_fixed(cbu_pkg::CH_NL, 8'h40,
			cbu_pkg::LEN_W'(cbu_pkg::RECORD_MAX), 1'b0));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(cbu_pkg::MODE_A2IBM)));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_RECLEN, 0));
		stim_tab.push_back(row_byte(8'h21));
		stim_tab.push_back(row_cfg(cbu_pkg::CFG_MODE, cbu_pkg::LEN_W'(cbu_pkg::MODE_COPY)));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (stim_tab[i]) begin
			if (stim_tab[i].is_cfg) cfg_write(stim_tab[i].idx, stim_tab[i].data);
			else push_byte(stim_tab[i].data[7:0], stim_tab[i].fixed, stim_tab[i].want);
		end

		// random phases: new settings, then a record-shaped stream
		byte_cnt = 0;
		first_phase = 1'b1;
		while (byte_cnt < RANDOM_ITEMS) begin
			steady = 1'b0;
			if (first_phase || $urandom_range(0, 1)) begin
				d = ($urandom_range(0, 7) == 0) ?
					cbu_pkg::LEN_W'($urandom_range(0, 8191)) : '0;
				d[2:0] = 3'($urandom_range(0, 7));
				cfg_write(cbu_pkg::CFG_MODE, d);
			end
			if (first_phase || $urandom_range(0, 2) == 0) begin
				d = ($urandom_range(0, 7) == 0) ?
					cbu_pkg::LEN_W'($urandom_range(0, 8191)) : '0;
				d[0] = 1'($urandom_range(0, 1));
				cfg_write(cbu_pkg::CFG_FOLD_UPPER, d);
			end
			if (first_phase || $urandom_range(0, 2) == 0) begin
				d = ($urandom_range(0, 7) == 0) ?
					cbu_pkg::LEN_W'($urandom_range(0, 8191)) : '0;
				d[0] = 1'($urandom_range(0, 1));
				cfg_write(cbu_pkg::CFG_FOLD_LOWER, d);
			end
			if (first_phase || $urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				if (r < 10) d = '0;
				else if (r < 60) d = cbu_pkg::LEN_W'($urandom_range(1, 8));
				else if (r < 70) d = cbu_pkg::LEN_W'($urandom_range(9, 64));
				else if (r < 78) d = cbu_pkg::LEN_W'(cbu_pkg::RECORD_MAX);
				else if (r < 84) d = cbu_pkg::LEN_W'(cbu_pkg::RECORD_MAX + 1);
				else if (r < 90) d = 13'h1fff;
				else d = cbu_pkg::LEN_W'($urandom_range(0, 8191));
				cfg_write(cbu_pkg::CFG_RECLEN, d);
			end
			first_phase = 1'b0;
			steady = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 50);
			repeat (n) begin
				r = $urandom_range(0, 99);
				b = 8'($urandom_range(0, 255));
				case (mode_r) inside
					cbu_pkg::MODE_E2A: begin
						if (r < 30) b = EBC_SPACE;
						else if (r < 35) b = cbu_pkg::CH_SPACE;
					end
					cbu_pkg::MODE_UNBLOCK: begin
						if (r < 35) b = cbu_pkg::CH_SPACE;
						else if (r < 40) b = cbu_pkg::CH_NL;
						else if (r < 55) b = cbu_pkg::CH_LA + 8'($urandom_range(0, 25));
					end
					cbu_pkg::MODE_A2E, cbu_pkg::MODE_A2IBM, cbu_pkg::MODE_BLOCK: begin
						if (r < 12) b = cbu_pkg::CH_NL;
						else if (r < 20) b = cbu_pkg::CH_SPACE;
						else if (r < 33) b = cbu_pkg::CH_LA + 8'($urandom_range(0, 25));
						else if (r < 45) b = cbu_pkg::CH_UA + 8'($urandom_range(0, 25));
					end
					default: begin
						if (r < 20) b = cbu_pkg::CH_LA + 8'($urandom_range(0, 25));
						else if (r < 40) b = cbu_pkg::CH_UA + 8'($urandom_range(0, 25));
					end
				endcase
				push_byte(b, 1'b0, '0);
				byte_cnt++;
			end
		end

		// drain and let the pipeline settle
		in_valid = 1'b0;
		wait_drained();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
